[rtl/core/ezq_pkg.sv]
`timescale 1ns / 1ps
package ezq_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int ATAN_ENTRIES    = 24;
  localparam int NUM_ROT         = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  localparam int ANGLE_W   = 15;
  localparam int QUAT_W    = 16;
  localparam int CW        = 34;
  localparam int CS_W      = 18;
  localparam int IDX_W     = 5;
  localparam int MAG_PW    = 46;
  localparam int PAIR_W    = 2 * CS_W;
  localparam int TRIP_W    = PAIR_W + CS_W;
  localparam int SUM_W     = TRIP_W + 1;

  // pipeline: convert, round, rotations, cos/sin round, pair mul, triple mul, sum, out
  localparam int DEPTH     = NUM_ROT + 7;
  localparam int POS_CS    = NUM_ROT + 2;
  localparam int POS_P1    = NUM_ROT + 3;
  localparam int POS_P2    = NUM_ROT + 4;
  localparam int POS_SUM   = NUM_ROT + 5;
  localparam int POS_OUT   = NUM_ROT + 6;

  localparam logic signed [31:0] ANGLE_LIM = 32'(180 * (1 << ANGLE_FRAC_BITS));
  localparam logic [MAG_PW-1:0]  DEG_TO_RAD_Q36 = MAG_PW'(64'd1199381129);
  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(64'sd652032874);
  localparam logic signed [SUM_W-1:0] ONE_Q14 = SUM_W'(16384);

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [CW-1:0]      cword_t;

  function automatic cword_t atan_q30(input logic [IDX_W-1:0] i);
    cword_t r;
    case (i)
      5'd0:    r = CW'(64'sd843314856);
      5'd1:    r = CW'(64'sd497837829);
      5'd2:    r = CW'(64'sd263043836);
      5'd3:    r = CW'(64'sd133525158);
      5'd4:    r = CW'(64'sd67021686);
      5'd5:    r = CW'(64'sd33543515);
      5'd6:    r = CW'(64'sd16775850);
      5'd7:    r = CW'(64'sd8388437);
      5'd8:    r = CW'(64'sd4194282);
      5'd9:    r = CW'(64'sd2097149);
      5'd10:   r = CW'(64'sd1048575);
      5'd11:   r = CW'(64'sd524287);
      5'd12:   r = CW'(64'sd262143);
      5'd13:   r = CW'(64'sd131071);
      5'd14:   r = CW'(64'sd65535);
      5'd15:   r = CW'(64'sd32767);
      5'd16:   r = CW'(64'sd16383);
      5'd17:   r = CW'(64'sd8191);
      5'd18:   r = CW'(64'sd4095);
      5'd19:   r = CW'(64'sd2047);
      5'd20:   r = CW'(64'sd1023);
      5'd21:   r = CW'(64'sd511);
      5'd22:   r = CW'(64'sd255);
      5'd23:   r = CW'(64'sd127);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/ezq_cordic_rot.sv]
`timescale 1ns / 1ps
module ezq_cordic_rot (
  input  ezq_pkg::cword_t               x_in,
  input  ezq_pkg::cword_t               y_in,
  input  ezq_pkg::cword_t               z_in,
  input  logic [ezq_pkg::IDX_W-1:0]     idx,
  output ezq_pkg::cword_t               x_out,
  output ezq_pkg::cword_t               y_out,
  output ezq_pkg::cword_t               z_out
);
  import ezq_pkg::*;

  cword_t xs;
  cword_t ys;
  cword_t at;

  assign xs = x_in >>> idx;
  assign ys = y_in >>> idx;
  assign at = atan_q30(idx);

  always_comb begin
    if (!z_in[CW-1]) begin
      x_out = x_in - ys;
      y_out = y_in + xs;
      z_out = z_in - at;
    end else begin
      x_out = x_in + ys;
      y_out = y_in - xs;
      z_out = z_in + at;
    end
  end

endmodule

[rtl/core/euler_zyx_to_quaternion_core.sv]
`timescale 1ns / 1ps
// channel | signals                                       | direction
// in      | in_valid, in_stall, roll/pitch/yaw_angle      | into block
// out     | out_valid, out_stall, quat_w/x/y/z            | out of block
//
// One transaction per cycle while the output is not stalled, a rate set by the
// unrolled rotation stages and multipliers.
// Reset clears only the stage valid bits.
// Each stage holds while the stage after it is full and stalled; empty
// stages fill behind a stalled output, so nothing is lost or repeated.
module euler_zyx_to_quaternion_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ezq_pkg::angle_t roll_angle,
  input  ezq_pkg::angle_t pitch_angle,
  input  ezq_pkg::angle_t yaw_angle,
  output logic            out_valid,
  input  logic            out_stall,
  output ezq_pkg::quat_t  quat_w,
  output ezq_pkg::quat_t  quat_x,
  output ezq_pkg::quat_t  quat_y,
  output ezq_pkg::quat_t  quat_z
);
  import ezq_pkg::*;

  logic [DEPTH-1:0] v;
  logic [DEPTH:0]   en;

  assign en[DEPTH] = !out_stall;
  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (en[i]) begin
          v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[DEPTH-1];

  // angle convert
  angle_t              ang [3];
  logic [MAG_PW-1:0]   m0 [3];
  logic                n0 [3];
  cword_t              z1 [3];

  assign ang[0] = roll_angle;
  assign ang[1] = pitch_angle;
  assign ang[2] = yaw_angle;

  cword_t cx [NUM_ROT][3];
  cword_t cy [NUM_ROT][3];
  cword_t cz [NUM_ROT][3];

  genvar a, j;
  generate
    for (a = 0; a < 3; a++) begin : g_axis
      logic signed [31:0] ae;
      logic signed [31:0] sat;
      logic signed [31:0] mag;
      logic [MAG_PW-1:0]  prod;
      logic [MAG_PW-1:0]  rnd;
      cword_t             rcw;

      always_comb begin
        ae  = 32'(ang[a]);
        sat = ae;
        if (ae > ANGLE_LIM) sat = ANGLE_LIM;
        if (ae < -ANGLE_LIM) sat = -ANGLE_LIM;
        mag  = sat[31] ? -sat : sat;
        prod = MAG_PW'(mag[ANGLE_W-1:0]) * DEG_TO_RAD_Q36;
        rnd  = (m0[a] + (MAG_PW'(1) << (6 + ANGLE_FRAC_BITS))) >> (7 + ANGLE_FRAC_BITS);
        rcw  = CW'(rnd);
      end

      always_ff @(posedge clk) begin
        if (en[0]) begin
          m0[a] <= prod;
          n0[a] <= sat[31];
        end
        if (en[1]) begin
          z1[a] <= n0[a] ? -rcw : rcw;
        end
      end

      for (j = 0; j < NUM_ROT; j++) begin : g_rot
        cword_t xi, yi, zi, xo, yo, zo;
        if (j == 0) begin : g_first
          assign xi = GAIN_Q30;
          assign yi = '0;
          assign zi = z1[a];
        end else begin : g_next
          assign xi = cx[j-1][a];
          assign yi = cy[j-1][a];
          assign zi = cz[j-1][a];
        end
        ezq_cordic_rot u_rot (
          .x_in (xi),
          .y_in (yi),
          .z_in (zi),
          .idx  (IDX_W'(j)),
          .x_out(xo),
          .y_out(yo),
          .z_out(zo)
        );
        always_ff @(posedge clk) begin
          if (en[2+j]) begin
            cx[j][a] <= xo;
            cy[j][a] <= yo;
            cz[j][a] <= zo;
          end
        end
      end
    end
  endgenerate

  // half-angle cos/sin to Q16
  logic signed [CS_W-1:0] hc [3];
  logic signed [CS_W-1:0] hs [3];
  cword_t xr [3];
  cword_t yr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xr[i] = (cx[NUM_ROT-1][i] + CW'(8192)) >>> 14;
      yr[i] = (cy[NUM_ROT-1][i] + CW'(8192)) >>> 14;
    end
  end

  always_ff @(posedge clk) begin
    if (en[POS_CS]) begin
      for (int i = 0; i < 3; i++) begin
        hc[i] <= xr[i][CS_W-1:0];
        hs[i] <= yr[i][CS_W-1:0];
      end
    end
  end

  // pair products, 18 x 18 signed
  logic signed [PAIR_W-1:0] p_cc, p_ss, p_sc, p_cs;
  logic signed [CS_W-1:0]   cy_d, sy_d;

  always_ff @(posedge clk) begin
    if (en[POS_P1]) begin
      p_cc <= hc[0] * hc[1];
      p_ss <= hs[0] * hs[1];
      p_sc <= hs[0] * hc[1];
      p_cs <= hc[0] * hs[1];
      cy_d <= hc[2];
      sy_d <= hs[2];
    end
  end

  // triple products, 36 x 18 signed
  logic signed [TRIP_W-1:0] t_ccc, t_sss, t_scc, t_css, t_csc, t_scs, t_ccs, t_ssc;

  always_ff @(posedge clk) begin
    if (en[POS_P2]) begin
      t_ccc <= p_cc * cy_d;
      t_sss <= p_ss * sy_d;
      t_scc <= p_sc * cy_d;
      t_css <= p_cs * sy_d;
      t_csc <= p_cs * cy_d;
      t_scs <= p_sc * sy_d;
      t_ccs <= p_cc * sy_d;
      t_ssc <= p_ss * cy_d;
    end
  end

  logic signed [SUM_W-1:0] s_w, s_x, s_y, s_z;

  always_ff @(posedge clk) begin
    if (en[POS_SUM]) begin
      s_w <= SUM_W'(t_ccc) + SUM_W'(t_sss);
      s_x <= SUM_W'(t_scc) - SUM_W'(t_css);
      s_y <= SUM_W'(t_csc) + SUM_W'(t_scs);
      s_z <= SUM_W'(t_ccs) - SUM_W'(t_ssc);
    end
  end

  function automatic quat_t to_q14(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] r;
    r = (s + (SUM_W'(1) << 33)) >>> 34;
    if (r > ONE_Q14) r = ONE_Q14;
    if (r < -ONE_Q14) r = -ONE_Q14;
    return r[QUAT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en[POS_OUT]) begin
      quat_w <= to_q14(s_w);
      quat_x <= to_q14(s_x);
      quat_y <= to_q14(s_y);
      quat_z <= to_q14(s_z);
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst) in_stall |-> &v)
    else $error("input stalled with an empty stage");
  a_w_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384))
    else $error("quat_w out of range");
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

[tb/euler_zyx_to_quaternion_core_tb.sv]
`timescale 1ns / 1ps
module euler_zyx_to_quaternion_core_tb;
  import ezq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * DEPTH + 10;
  localparam longint HALF_DEG_Q36 = 64'd1199381129;
  localparam longint CORDIC_K_Q30 = 64'd652032874;
  localparam longint UNIT_Q14     = 16384;

  typedef struct packed {
    quat_t w;
    quat_t x;
    quat_t y;
    quat_t z;
  } quat_rec_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  angle_t roll_angle = '0;
  angle_t pitch_angle = '0;
  angle_t yaw_angle = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  quat_t  quat_w, quat_x, quat_y, quat_z;

  quat_rec_t quat_expected[$];
  int        errors = 0;
  int        snd_idle_pct = 0;
  int        rcv_idle_pct = 0;
  logic      hold_req = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_cycles = 0;
  int        quiet_cycles = 0;

  longint atan_tab[24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  euler_zyx_to_quaternion_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
  );

  always #2 clk = ~clk;

  function automatic longint half_angle_rad(angle_t a);
    longint v, lim, mag, r;
    v = a;
    lim = 180 * (1 << ANGLE_FRAC_BITS);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    mag = (v < 0) ? -v : v;
    r = (mag * HALF_DEG_Q36 + (64'sd1 <<< (6 + ANGLE_FRAC_BITS))) >>> (7 + ANGLE_FRAC_BITS);
    return (v < 0) ? -r : r;
  endfunction

  task automatic rotate_half(input longint z_in, output longint c, output longint s);
    longint x, y, z, nx;
    int     n;
    x = CORDIC_K_Q30;
    y = 0;
    z = z_in;
    n = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
    end
    c = (x + (64'sd1 <<< 13)) >>> 14;
    s = (y + (64'sd1 <<< 13)) >>> 14;
  endtask

  function automatic quat_t round_q14(longint sum);
    longint v;
    v = (sum + (64'sd1 <<< 33)) >>> 34;
    if (v > UNIT_Q14) v = UNIT_Q14;
    if (v < -UNIT_Q14) v = -UNIT_Q14;
    return quat_t'(v);
  endfunction

  task automatic predict_quat(input angle_t r, input angle_t p, input angle_t y);
    longint cr, sr, cp, sp, cy, sy;
    quat_rec_t q;
    rotate_half(half_angle_rad(r), cr, sr);
    rotate_half(half_angle_rad(p), cp, sp);
    rotate_half(half_angle_rad(y), cy, sy);
    q.w = round_q14(cr * cp * cy + sr * sp * sy);
    q.x = round_q14(sr * cp * cy - cr * sp * sy);
    q.y = round_q14(cr * sp * cy + sr * cp * sy);
    q.z = round_q14(cr * cp * sy - sr * sp * cy);
    quat_expected.push_back(q);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // input monitor
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) predict_quat(roll_angle, pitch_angle, yaw_angle);
  end

  // output checker
  always @(posedge clk) begin
    quat_rec_t q;
    if (!rst && out_valid && !out_stall) begin
      if (quat_expected.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        q = quat_expected.pop_front();
        if (quat_w !== q.w) report_mismatch("quat_w", quat_w, q.w);
        if (quat_x !== q.x) report_mismatch("quat_x", quat_x, q.x);
        if (quat_y !== q.y) report_mismatch("quat_y", quat_y, q.y);
        if (quat_z !== q.z) report_mismatch("quat_z", quat_z, q.z);
      end
    end
  end

  // receiver stall, with one long hold on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_done <= 1'b1;
      hold_cycles <= 3 * DEPTH - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_angles(input angle_t r, input angle_t p, input angle_t y);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    roll_angle <= r;
    pitch_angle <= p;
    yaw_angle <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic angle_t rand_angle();
    int k;
    k = $urandom_range(99);
    if (k < 75) return angle_t'($urandom_range(23040) - 11520);
    if (k < 90) return angle_t'($urandom);
    case ($urandom_range(5))
      0: return angle_t'(11520);
      1: return angle_t'(-11520);
      2: return angle_t'(0);
      3: return angle_t'(5760);
      4: return angle_t'(-5760);
      default: return angle_t'(-16384);
    endcase
  endfunction

  task automatic test_directed();
    angle_t vals[10] = '{0, 11520, -11520, 11521, -11521, 16383, -16384, 5760, -5760, 1};
    for (int i = 0; i < 10; i++) send_angles(vals[i], vals[i], vals[i]);
    send_angles(11520, 0, 0);
    send_angles(0, 11520, 0);
    send_angles(0, 0, 11520);
    send_angles(5760, 5760, 0);
    send_angles(0, 5760, 5760);
    send_angles(-5760, 5760, -5760);
    send_angles(16383, -16384, 16383);
    send_angles(-1, -1, -1);
    send_angles(2880, -2880, 2880);
    send_angles(angle_t'(15'h2AAA), angle_t'(15'h5555), angle_t'(15'h2AAA));
    send_angles(angle_t'(15'h5555), angle_t'(15'h2AAA), angle_t'(15'h5555));
  endtask

  task automatic test_random(input int n, input int snd_pct, input int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int i = 0; i < n; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 120; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(450, 8, 81);
    test_random(450, 81, 8);
    test_random(450, 0, 0);
    test_backpressure();
    in_valid <= 1'b0;
    rcv_idle_pct = 0;
    while (quat_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ezq_pkg.sv
rtl/core/ezq_cordic_rot.sv
rtl/core/euler_zyx_to_quaternion_core.sv
tb/euler_zyx_to_quaternion_core_tb.sv
